@@ rtl/cts_pkg.sv @@
// Shared types and constants of the circular triangular smoother.
package cts_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int COORD_W  = 16;
  localparam int SMOOTH_W = 20;
  localparam int HW_W     = 8;
  localparam int STRIDE_W = 4;
  localparam int QIDX_W   = 10;
  localparam int FRAC_W   = 4;
  localparam int PROD_W   = HW_W + COORD_W;
  localparam int ACC_W    = 32;
  localparam int DEN_W    = 2 * HW_W;
  localparam int NUM_W    = ACC_W + FRAC_W;
  localparam int TAPC_W   = HW_W + 1;
  localparam int DIVC_W   = 5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [HW_W-1:0]     HALF_WIDTH_RST = 8'd8;
  localparam logic [STRIDE_W-1:0] TAP_STRIDE_RST = 4'd1;

  localparam logic REG_HALF_WIDTH = 1'b0;
  localparam logic REG_TAP_STRIDE = 1'b1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SMOD,
    ST_BACK,
    ST_ACC,
    ST_DRAIN,
    ST_DLOAD,
    ST_DSTEP,
    ST_DONE
  } state_t;

endpackage

@@ rtl/circular_triangular_smoother_top.sv @@
// Circular triangular smoother: outline point store, tap sequencer and shared divider.
//
// Usage:
//   Input channel (in_valid/in_ready): in_func selects a load or a query.
//   A load writes one outline point (in_first_point restarts the outline at
//   index zero) unless the outline is full; no result follows.
//   A query returns one item on the result channel (out_valid/out_ready) with
//   the smoothed x and y in 4 fraction bits and a result_valid flag.
//   A valid query passes through the setup state, reduces the stride modulo
//   the outline length, steps back to the first tap, reads the point memory
//   one tap a cycle through one multiply-accumulate per coordinate, drains,
//   divides x and then y in the shared restoring divider and is written
//   into the output register, which raises out_valid.
//   An invalid query goes from the setup state straight to the output
//   register.
//   in_ready is low while a query is at work; loads are taken back to back.
//   The result sits in an output register; when the receiver stalls, the
//   block holds the finished item, still takes loads, and holds a second
//   finished query until the register frees.
//   The configuration port takes half_width at 0x0 and tap_stride at 0x4.
//   Reset empties the outline and restores half_width 8 and tap_stride 1;
//   the point memory is not cleared.
module circular_triangular_smoother_top #(
  parameter int MAX_POINTS = cts_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cts_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [cts_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [cts_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic                                in_first_point,
  input  logic [cts_pkg::COORD_W-1:0]         in_coord_x,
  input  logic [cts_pkg::COORD_W-1:0]         in_coord_y,
  input  logic [cts_pkg::QIDX_W-1:0]          in_query_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cts_pkg::SMOOTH_W-1:0]        out_smooth_x,
  output logic [cts_pkg::SMOOTH_W-1:0]        out_smooth_y,
  output logic                                out_result_valid
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int QW = (CW > cts_pkg::QIDX_W) ? CW : cts_pkg::QIDX_W;
  localparam int HW = cts_pkg::HW_W;
  localparam int TW = cts_pkg::TAPC_W;
  localparam int SW = cts_pkg::SMOOTH_W;
  localparam int DW = cts_pkg::DEN_W;

  logic [cts_pkg::COORD_W-1:0] mem_x [MAX_POINTS];
  logic [cts_pkg::COORD_W-1:0] mem_y [MAX_POINTS];

  cts_pkg::state_t state_r, state_nxt;

  logic [HW-1:0]                hw_r;
  logic [cts_pkg::STRIDE_W-1:0] stride_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic [QW-1:0]                qidx_r, qidx_nxt;
  logic [AW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                smod_r, smod_nxt;
  logic [TW-1:0]                cnt_r, cnt_nxt;
  logic [HW-1:0]                w_r, w_nxt;
  logic [HW-1:0]                w_d_r;
  logic                         tap_vld_r;
  logic [cts_pkg::COORD_W-1:0]  rdx_r, rdy_r;
  logic [cts_pkg::ACC_W-1:0]    accx_r, accx_nxt, accy_r, accy_nxt;
  logic [DW-1:0]                den_r, den_nxt;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [SW-1:0]                low_r, low_nxt;
  logic [cts_pkg::DIVC_W-1:0]   dcnt_r, dcnt_nxt;
  logic                         dsel_r, dsel_nxt;
  logic [SW-1:0]                qx_r, qx_nxt;
  logic [SW-1:0]                res_sx_r, res_sx_nxt, res_sy_r, res_sy_nxt;
  logic                         res_rv_r, res_rv_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [SW-1:0]                out_sx_r, out_sy_r;
  logic                         out_rv_r;

  logic                         in_acc, load_acc, query_acc, mem_we, cfg_we, out_load;
  logic [AW-1:0]                wr_addr;
  logic                         bad_query;
  logic [CW:0]                  pos_w, back_sum, fwd_sum;
  logic [AW-1:0]                pos_back, pos_fwd;
  logic [TW-1:0]                hw_w, back_last, acc_last;
  logic [cts_pkg::PROD_W-1:0]   prod_x, prod_y;
  logic [cts_pkg::NUM_W-1:0]    num;
  logic [DW:0]                  trial;
  logic                         q_bit;

  // Handshakes
  assign in_acc     = in_valid && in_ready;
  assign load_acc   = in_acc && (in_func == cts_pkg::FUNC_LOAD);
  assign query_acc  = in_acc && (in_func == cts_pkg::FUNC_QUERY);
  assign mem_we     = load_acc && (in_first_point || (count_r < CW'(MAX_POINTS)));
  assign wr_addr    = in_first_point ? '0 : count_r[AW-1:0];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_load   = (state_r == cts_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // Address arithmetic
  assign hw_w      = TW'(hw_r);
  assign back_last = hw_w - TW'(2);
  assign acc_last  = {hw_r, 1'b0} - TW'(2);
  assign bad_query = (hw_r == '0) || (QW'(count_r) <= QW'(hw_r)) ||
                     (qidx_r >= QW'(count_r));
  assign pos_w     = (CW+1)'(pos_r);
  assign back_sum  = (pos_w >= (CW+1)'(smod_r)) ? pos_w - (CW+1)'(smod_r)
                   : pos_w + (CW+1)'(count_r) - (CW+1)'(smod_r);
  assign fwd_sum   = pos_w + (CW+1)'(smod_r);
  assign pos_back  = back_sum[AW-1:0];
  assign pos_fwd   = (fwd_sum >= (CW+1)'(count_r)) ?
                     AW'(fwd_sum - (CW+1)'(count_r)) : fwd_sum[AW-1:0];

  // Multiply-accumulate and divider step
  assign prod_x = cts_pkg::PROD_W'(w_d_r) * cts_pkg::PROD_W'(rdx_r);
  assign prod_y = cts_pkg::PROD_W'(w_d_r) * cts_pkg::PROD_W'(rdy_r);
  assign num    = {(dsel_r ? accy_r : accx_r), {cts_pkg::FRAC_W{1'b0}}} +
                  cts_pkg::NUM_W'(den_r >> 1);
  assign trial  = {rem_r, low_r[SW-1]};
  assign q_bit  = trial >= (DW+1)'(den_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cts_pkg::ST_IDLE: begin
        if (query_acc) state_nxt = cts_pkg::ST_SETUP;
      end
      cts_pkg::ST_SETUP: begin
        state_nxt = bad_query ? cts_pkg::ST_DONE : cts_pkg::ST_SMOD;
      end
      cts_pkg::ST_SMOD: begin
        if (smod_r < count_r) begin
          state_nxt = (hw_r == HW'(1)) ? cts_pkg::ST_ACC : cts_pkg::ST_BACK;
        end
      end
      cts_pkg::ST_BACK: begin
        if (cnt_r == back_last) state_nxt = cts_pkg::ST_ACC;
      end
      cts_pkg::ST_ACC: begin
        if (cnt_r == acc_last) state_nxt = cts_pkg::ST_DRAIN;
      end
      cts_pkg::ST_DRAIN: state_nxt = cts_pkg::ST_DLOAD;
      cts_pkg::ST_DLOAD: state_nxt = cts_pkg::ST_DSTEP;
      cts_pkg::ST_DSTEP: begin
        if (dcnt_r == cts_pkg::DIVC_W'(SW - 1)) begin
          state_nxt = dsel_r ? cts_pkg::ST_DONE : cts_pkg::ST_DLOAD;
        end
      end
      cts_pkg::ST_DONE: begin
        if (out_load) state_nxt = cts_pkg::ST_IDLE;
      end
      default: state_nxt = cts_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    count_nxt  = count_r;
    qidx_nxt   = qidx_r;
    pos_nxt    = pos_r;
    smod_nxt   = smod_r;
    cnt_nxt    = cnt_r;
    w_nxt      = w_r;
    accx_nxt   = accx_r;
    accy_nxt   = accy_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    low_nxt    = low_r;
    dcnt_nxt   = dcnt_r;
    dsel_nxt   = dsel_r;
    qx_nxt     = qx_r;
    res_sx_nxt = res_sx_r;
    res_sy_nxt = res_sy_r;
    res_rv_nxt = res_rv_r;
    if (tap_vld_r) begin
      accx_nxt = accx_r + cts_pkg::ACC_W'(prod_x);
      accy_nxt = accy_r + cts_pkg::ACC_W'(prod_y);
    end
    case (state_r)
      cts_pkg::ST_IDLE: begin
        if (load_acc) begin
          if (in_first_point) count_nxt = CW'(1);
          else if (count_r < CW'(MAX_POINTS)) count_nxt = count_r + CW'(1);
        end
        if (query_acc) qidx_nxt = QW'(in_query_index);
      end
      cts_pkg::ST_SETUP: begin
        den_nxt    = DW'(hw_r) * DW'(hw_r);
        smod_nxt   = CW'(stride_r);
        pos_nxt    = qidx_r[AW-1:0];
        accx_nxt   = '0;
        accy_nxt   = '0;
        dsel_nxt   = 1'b0;
        res_sx_nxt = '0;
        res_sy_nxt = '0;
        res_rv_nxt = 1'b0;
      end
      cts_pkg::ST_SMOD: begin
        if (smod_r >= count_r) smod_nxt = smod_r - count_r;
        cnt_nxt = '0;
        w_nxt   = HW'(1);
      end
      cts_pkg::ST_BACK: begin
        pos_nxt = pos_back;
        cnt_nxt = (cnt_r == back_last) ? '0 : cnt_r + TW'(1);
      end
      cts_pkg::ST_ACC: begin
        pos_nxt = pos_fwd;
        cnt_nxt = cnt_r + TW'(1);
        w_nxt   = (cnt_r < hw_w - TW'(1)) ? w_r + HW'(1) : w_r - HW'(1);
      end
      cts_pkg::ST_DLOAD: begin
        rem_nxt  = num[cts_pkg::NUM_W-1 -: DW];
        low_nxt  = num[SW-1:0];
        dcnt_nxt = '0;
      end
      cts_pkg::ST_DSTEP: begin
        rem_nxt  = q_bit ? DW'(trial - (DW+1)'(den_r)) : trial[DW-1:0];
        low_nxt  = {low_r[SW-2:0], q_bit};
        dcnt_nxt = dcnt_r + cts_pkg::DIVC_W'(1);
        if (dcnt_r == cts_pkg::DIVC_W'(SW - 1)) begin
          if (dsel_r) begin
            res_sx_nxt = qx_r;
            res_sy_nxt = low_nxt;
            res_rv_nxt = 1'b1;
          end else begin
            qx_nxt   = low_nxt;
            dsel_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Port outputs
  always_comb begin
    in_ready      = (state_r == cts_pkg::ST_IDLE);
    cfg_pready    = 1'b1;
    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
    case (cfg_paddr[2])
      cts_pkg::REG_HALF_WIDTH: cfg_prdata = cts_pkg::CFG_DATA_W'(hw_r);
      cts_pkg::REG_TAP_STRIDE: cfg_prdata = cts_pkg::CFG_DATA_W'(stride_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_smooth_x     = out_sx_r;
  assign out_smooth_y     = out_sy_r;
  assign out_result_valid = out_rv_r;

  // Point memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_x[wr_addr] <= in_coord_x;
      mem_y[wr_addr] <= in_coord_y;
    end
    rdx_r <= mem_x[pos_r];
    rdy_r <= mem_y[pos_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cts_pkg::ST_IDLE;
      count_r     <= '0;
      hw_r        <= cts_pkg::HALF_WIDTH_RST;
      stride_r    <= cts_pkg::TAP_STRIDE_RST;
      tap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tap_vld_r   <= (state_r == cts_pkg::ST_ACC);
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_paddr[2])
          cts_pkg::REG_HALF_WIDTH: hw_r     <= cfg_pwdata[HW-1:0];
          cts_pkg::REG_TAP_STRIDE: stride_r <= cfg_pwdata[cts_pkg::STRIDE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    qidx_r   <= qidx_nxt;
    pos_r    <= pos_nxt;
    smod_r   <= smod_nxt;
    cnt_r    <= cnt_nxt;
    w_r      <= w_nxt;
    w_d_r    <= w_r;
    accx_r   <= accx_nxt;
    accy_r   <= accy_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    low_r    <= low_nxt;
    dcnt_r   <= dcnt_nxt;
    dsel_r   <= dsel_nxt;
    qx_r     <= qx_nxt;
    res_sx_r <= res_sx_nxt;
    res_sy_r <= res_sy_nxt;
    res_rv_r <= res_rv_nxt;
    if (out_load) begin
      out_sx_r <= res_sx_r;
      out_sy_r <= res_sy_r;
      out_rv_r <= res_rv_r;
    end
  end

endmodule

@@ bench/circular_triangular_smoother_top_tb.sv @@
// Self-checking bench for the circular triangular smoother: point loads, queries, APB setup.
`timescale 1ns / 1ps

typedef struct packed {
  logic [cts_pkg::SMOOTH_W-1:0] sx;
  logic [cts_pkg::SMOOTH_W-1:0] sy;
  logic                         ok;
} smooth_res_t;

class smoothing_checker;
  logic [cts_pkg::COORD_W-1:0] outline_x [cts_pkg::MAX_POINTS_DEF];
  logic [cts_pkg::COORD_W-1:0] outline_y [cts_pkg::MAX_POINTS_DEF];
  int                          outline_len;
  int                          hw;
  int                          stride;
  int                          errors;
  smooth_res_t                 pending_points[$];

  function new();
    outline_len = 0;
    hw          = int'(cts_pkg::HALF_WIDTH_RST);
    stride      = int'(cts_pkg::TAP_STRIDE_RST);
    errors      = 0;
  endfunction

  function void set_reg(logic idx, int value);
    if (idx == cts_pkg::REG_HALF_WIDTH) begin
      hw = value & 'hFF;
    end else begin
      stride = value & 'hF;
    end
  endfunction

  function smooth_res_t smooth_point(logic [cts_pkg::QIDX_W-1:0] qi);
    smooth_res_t       r;
    longint unsigned   sum_x;
    longint unsigned   sum_y;
    longint unsigned   den;
    longint unsigned   wt;
    longint            pos;
    longint            m;
    longint            am;
    longint            qn;
    r  = '0;
    qn = longint'(qi);
    if (hw == 0 || outline_len <= hw || qn >= outline_len) begin
      return r;
    end
    sum_x = 0;
    sum_y = 0;
    for (m = -hw; m <= hw; m++) begin
      am  = (m < 0) ? -m : m;
      wt  = hw - am;
      pos = (qn + m * stride) % outline_len;
      if (pos < 0) begin
        pos += outline_len;
      end
      sum_x += wt * 64'(outline_x[pos]);
      sum_y += wt * 64'(outline_y[pos]);
    end
    den  = longint'(hw) * longint'(hw);
    r.sx = cts_pkg::SMOOTH_W'((sum_x * 16 + den / 2) / den);
    r.sy = cts_pkg::SMOOTH_W'((sum_y * 16 + den / 2) / den);
    r.ok = 1'b1;
    return r;
  endfunction

  function void note(logic func, logic first, logic [cts_pkg::COORD_W-1:0] x,
                     logic [cts_pkg::COORD_W-1:0] y, logic [cts_pkg::QIDX_W-1:0] qi);
    if (func == cts_pkg::FUNC_LOAD) begin
      if (first) begin
        outline_x[0] = x;
        outline_y[0] = y;
        outline_len  = 1;
      end else if (outline_len < cts_pkg::MAX_POINTS_DEF) begin
        outline_x[outline_len] = x;
        outline_y[outline_len] = y;
        outline_len++;
      end
    end else begin
      pending_points.insert(pending_points.size(), smooth_point(qi));
    end
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch %s: got %0h, want %0h", what, got, want);
  endtask

  task check(logic [cts_pkg::SMOOTH_W-1:0] sx, logic [cts_pkg::SMOOTH_W-1:0] sy, logic ok);
    smooth_res_t want;
    if (pending_points.size() == 0) begin
      report("unexpected result, smooth_x", 64'(sx), 64'd0);
      return;
    end
    want = pending_points.pop_front();
    if (sx !== want.sx) begin
      report("smooth_x", 64'(sx), 64'(want.sx));
    end
    if (sy !== want.sy) begin
      report("smooth_y", 64'(sy), 64'(want.sy));
    end
    if (ok !== want.ok) begin
      report("result_valid", 64'(ok), 64'(want.ok));
    end
  endtask
endclass

module circular_triangular_smoother_top_tb;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [cts_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [cts_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [cts_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_func;
  logic                           in_first_point;
  logic [cts_pkg::COORD_W-1:0]    in_coord_x;
  logic [cts_pkg::COORD_W-1:0]    in_coord_y;
  logic [cts_pkg::QIDX_W-1:0]     in_query_index;
  logic                           out_valid;
  logic                           out_ready;
  logic [cts_pkg::SMOOTH_W-1:0]   out_smooth_x;
  logic [cts_pkg::SMOOTH_W-1:0]   out_smooth_y;
  logic                           out_result_valid;

  smoothing_checker sb;
  logic             gaps_on;
  logic             long_hold;
  logic             hold_done;
  int               quiet_cycles;
  int               i;

  circular_triangular_smoother_top i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check(out_smooth_x, out_smooth_y, out_result_valid);
      end
      if (in_valid && in_ready) begin
        sb.note(in_func, in_first_point, in_coord_x, in_coord_y, in_query_index);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end
    end
  end

  function automatic logic [cts_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return cts_pkg::COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(logic func, logic first, logic [cts_pkg::COORD_W-1:0] x,
                           logic [cts_pkg::COORD_W-1:0] y, logic [cts_pkg::QIDX_W-1:0] qi);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_func        = func;
    in_first_point = first;
    in_coord_x     = x;
    in_coord_y     = y;
    in_query_index = qi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic query(logic [cts_pkg::QIDX_W-1:0] qi);
    send_item(cts_pkg::FUNC_QUERY, 1'($urandom_range(0, 1)), rand_coord(), rand_coord(), qi);
  endtask

  task automatic load_outline(int len);
    send_item(cts_pkg::FUNC_LOAD, 1'b1, rand_coord(), rand_coord(),
              cts_pkg::QIDX_W'($urandom_range(0, 1023)));
    repeat (len - 1) begin
      send_item(cts_pkg::FUNC_LOAD, 1'b0, rand_coord(), rand_coord(),
                cts_pkg::QIDX_W'($urandom_range(0, 1023)));
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic mixed_phase(int hw, int stride, int n);
    int len;
    int pick;
    settle();
    write_reg(cts_pkg::REG_HALF_WIDTH, hw);
    write_reg(cts_pkg::REG_TAP_STRIDE, stride);
    len = ($urandom_range(0, 5) == 0) ? hw : hw + 1 + $urandom_range(0, 24);
    len = (len > cts_pkg::MAX_POINTS_DEF) ? cts_pkg::MAX_POINTS_DEF : ((len < 1) ? 1 : len);
    load_outline(len);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        if ($urandom_range(0, 4) != 0 && sb.outline_len > 0) begin
          query(cts_pkg::QIDX_W'($urandom_range(0, sb.outline_len - 1)));
        end else begin
          query(cts_pkg::QIDX_W'($urandom_range(0, 1023)));
        end
      end else if (pick < 18) begin
        send_item(cts_pkg::FUNC_LOAD, 1'b0, rand_coord(), rand_coord(),
                  cts_pkg::QIDX_W'($urandom_range(0, 1023)));
      end else if (pick == 18) begin
        load_outline($urandom_range(1, hw + 20));
      end else begin
        query(cts_pkg::QIDX_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    clk            = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_valid       = 1'b0;
    in_func        = cts_pkg::FUNC_LOAD;
    in_first_point = 1'b0;
    in_coord_x     = '0;
    in_coord_y     = '0;
    in_query_index = '0;
    gaps_on        = 1'b1;
    long_hold      = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    query(10'd0);
    send_item(cts_pkg::FUNC_LOAD, 1'b1, 16'hFFFF, 16'h0000, 10'h3FF);
    for (i = 1; i < 8; i++) begin
      send_item(cts_pkg::FUNC_LOAD, 1'b0, i[0] ? 16'h0000 : 16'hFFFF,
                i[0] ? 16'hFFFF : 16'h0000, 10'h000);
    end
    query(10'd3);
    send_item(cts_pkg::FUNC_LOAD, 1'b0, 16'hFFFF, 16'hFFFF, 10'h155);
    query(10'd0);
    query(10'd8);
    query(10'd9);
    query(10'h3FF);
    send_item(cts_pkg::FUNC_LOAD, 1'b1, 16'hFFFF, 16'hFFFF, 10'h2AA);
    repeat (8) send_item(cts_pkg::FUNC_LOAD, 1'b0, 16'hFFFF, 16'hFFFF, 10'h000);
    query(10'd4);
    settle();
    write_reg(cts_pkg::REG_HALF_WIDTH, 0);
    query(10'd2);
    settle();
    write_reg(cts_pkg::REG_HALF_WIDTH, 1);
    write_reg(cts_pkg::REG_TAP_STRIDE, 0);
    query(10'd5);
    settle();
    write_reg(cts_pkg::REG_TAP_STRIDE, 15);
    query(10'd0);

    settle();
    write_reg(cts_pkg::REG_HALF_WIDTH, 255);
    load_outline(300);
    repeat (3) send_item(cts_pkg::FUNC_LOAD, 1'b0, rand_coord(), rand_coord(), 10'h3FF);
    query(10'h3FF);
    query(10'h000);
    query(10'h1FF);
    query(10'h200);
    repeat (16) query(cts_pkg::QIDX_W'($urandom_range(0, 1023)));

    mixed_phase(1, 1, 30);
    mixed_phase(2, 15, 30);
    settle();
    long_hold = 1'b1;
    mixed_phase(4, 7, 40);
    mixed_phase($urandom_range(1, 24), $urandom_range(0, 15), 30);
    gaps_on = 1'b0;
    mixed_phase($urandom_range(1, 24), $urandom_range(0, 15), 40);

    settle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/cts_pkg.sv
rtl/circular_triangular_smoother_top.sv
bench/circular_triangular_smoother_top_tb.sv
